FILE: sv/stack_machine_execute_unit_assert.svh
// Assertion macros used by the stack machine execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SMEU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SMEU_ASSERT(lbl, prop, msg)
`define SMEU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/smeu_pkg.sv
// Types, opcodes, status codes and decode tables of the stack machine execute unit.
`default_nettype none
package smeu_pkg;

    localparam int DATA_DEPTH_DEF    = 512;
    localparam int CALL_DEPTH_DEF    = 256;
    localparam int HEAP_BYTES_DEF    = 32768;
    localparam int PROGRAM_BYTES_DEF = 32768;

    localparam logic [5:0] OP_NOP    = 6'd0;
    localparam logic [5:0] OP_EXIT   = 6'd1;
    localparam logic [5:0] OP_FAIL   = 6'd2;
    localparam logic [5:0] OP_PUSH   = 6'd3;
    localparam logic [5:0] OP_DROP   = 6'd4;
    localparam logic [5:0] OP_DUP    = 6'd5;
    localparam logic [5:0] OP_ROT    = 6'd6;
    localparam logic [5:0] OP_OVER   = 6'd7;
    localparam logic [5:0] OP_ADD    = 6'd8;
    localparam logic [5:0] OP_SUB    = 6'd9;
    localparam logic [5:0] OP_MUL    = 6'd10;
    localparam logic [5:0] OP_DIV    = 6'd11;
    localparam logic [5:0] OP_MOD    = 6'd12;
    localparam logic [5:0] OP_LAND   = 6'd13;
    localparam logic [5:0] OP_BAND   = 6'd14;
    localparam logic [5:0] OP_LOR    = 6'd15;
    localparam logic [5:0] OP_BOR    = 6'd16;
    localparam logic [5:0] OP_LNOT   = 6'd17;
    localparam logic [5:0] OP_BNOT   = 6'd18;
    localparam logic [5:0] OP_LXOR   = 6'd19;
    localparam logic [5:0] OP_BXOR   = 6'd20;
    localparam logic [5:0] OP_LNOR   = 6'd21;
    localparam logic [5:0] OP_BNOR   = 6'd22;
    localparam logic [5:0] OP_LXNOR  = 6'd23;
    localparam logic [5:0] OP_BXNOR  = 6'd24;
    localparam logic [5:0] OP_LOAD1  = 6'd25;
    localparam logic [5:0] OP_STORE8 = 6'd32;
    localparam logic [5:0] OP_JZ     = 6'd33;
    localparam logic [5:0] OP_CZ     = 6'd34;
    localparam logic [5:0] OP_JNZ    = 6'd35;
    localparam logic [5:0] OP_CNZ    = 6'd36;
    localparam logic [5:0] OP_JMP    = 6'd37;
    localparam logic [5:0] OP_CALL   = 6'd38;
    localparam logic [5:0] OP_RET    = 6'd39;
    localparam logic [5:0] OP_EQ     = 6'd40;
    localparam logic [5:0] OP_NE     = 6'd41;
    localparam logic [5:0] OP_LT     = 6'd42;
    localparam logic [5:0] OP_GT     = 6'd43;
    localparam logic [5:0] OP_LE     = 6'd44;
    localparam logic [5:0] OP_GE     = 6'd45;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXIT    = 3'd1;
    localparam logic [2:0] ST_FAIL    = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;
    localparam logic [2:0] ST_DIVZERO = 3'd5;
    localparam logic [2:0] ST_ILLEGAL = 3'd6;
    localparam logic [2:0] ST_BADADDR = 3'd7;

    typedef struct packed {
        logic [5:0]  mode;
        logic [63:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] next_pc;
        logic [63:0] top_value;
        logic [9:0]  stack_depth;
        logic        halted;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic [5:0] op;
    } alu_req_t;

    function automatic logic [1:0] pops_of(input logic [5:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (op == OP_ROT) begin
            n = 2'd3;
        end else if (op == OP_DROP || op == OP_DUP || op == OP_LNOT || op == OP_BNOT) begin
            n = 2'd1;
        end else if (op == OP_OVER || (op >= OP_ADD && op <= OP_BXNOR)
                     || (op >= OP_EQ && op <= OP_GE)) begin
            n = 2'd2;
        end else if (op >= OP_LOAD1 && op <= OP_STORE8) begin
            n = op[0] ? 2'd1 : 2'd2;
        end else if (op >= OP_JZ && op <= OP_CNZ) begin
            n = 2'd1;
        end
        return n;
    endfunction

    function automatic logic [1:0] pushes_of(input logic [5:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (op == OP_ROT || op == OP_OVER) begin
            n = 2'd3;
        end else if (op == OP_DUP) begin
            n = 2'd2;
        end else if (op == OP_PUSH || (op >= OP_ADD && op <= OP_BXNOR)
                     || (op >= OP_EQ && op <= OP_GE)) begin
            n = 2'd1;
        end else if (op >= OP_LOAD1 && op <= OP_STORE8) begin
            n = op[0] ? 2'd1 : 2'd0;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: sv/smeu_alu.sv
// Shared iterative arithmetic unit: one adder serves add, subtract, compares,
// shift-add multiply and restoring divide.
`default_nettype none
module smeu_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smeu_pkg::alu_req_t req,
    input  wire logic [63:0]       opnd_a,
    input  wire logic [63:0]       opnd_b,
    output logic                   done,
    output logic [63:0]            result
);
    import smeu_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  op_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [5:0]  step_reg;
    logic [63:0] result_reg;

    logic        is_mul;
    logic        is_div;
    logic [64:0] rem_sh;
    logic [64:0] add_x;
    logic [64:0] add_y;
    logic        add_sub;
    logic [65:0] sum;
    logic        carry;
    logic [63:0] acc_step;
    logic [63:0] single_res;
    logic        a_nz;
    logic        b_nz;

    assign is_mul = (op_reg == OP_MUL);
    assign is_div = (op_reg == OP_DIV) || (op_reg == OP_MOD);
    assign rem_sh = {acc_reg, x_reg[63]};
    assign a_nz   = (a_reg != 64'd0);
    assign b_nz   = (b_reg != 64'd0);

    always_comb begin
        if (is_mul) begin
            add_x   = {1'b0, acc_reg};
            add_y   = {1'b0, y_reg};
            add_sub = 1'b0;
        end else if (is_div) begin
            add_x   = rem_sh;
            add_y   = {1'b0, a_reg};
            add_sub = 1'b1;
        end else begin
            add_x   = {1'b0, b_reg};
            add_y   = {1'b0, a_reg};
            add_sub = (op_reg != OP_ADD);
        end
    end

    assign sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + 66'(add_sub);
    // The carry out is set exactly when the subtrahend does not exceed the minuend.
    assign carry = sum[65];

    always_comb begin
        if (is_mul) begin
            acc_step = x_reg[0] ? sum[63:0] : acc_reg;
        end else begin
            acc_step = carry ? sum[63:0] : rem_sh[63:0];
        end
    end

    always_comb begin
        unique case (op_reg)
            OP_ADD, OP_SUB: single_res = sum[63:0];
            OP_LAND:  single_res = 64'(b_nz && a_nz);
            OP_BAND:  single_res = b_reg & a_reg;
            OP_LOR:   single_res = 64'(b_nz || a_nz);
            OP_BOR:   single_res = b_reg | a_reg;
            OP_LNOT:  single_res = 64'(!a_nz);
            OP_BNOT:  single_res = ~a_reg;
            OP_LXOR:  single_res = 64'(a_nz != b_nz);
            OP_BXOR:  single_res = b_reg ^ a_reg;
            OP_LNOR:  single_res = 64'(!(a_nz || b_nz));
            OP_BNOR:  single_res = ~(b_reg | a_reg);
            OP_LXNOR: single_res = 64'(a_nz == b_nz);
            OP_BXNOR: single_res = ~(b_reg ^ a_reg);
            OP_EQ:    single_res = 64'(b_reg == a_reg);
            OP_NE:    single_res = 64'(b_reg != a_reg);
            OP_LT:    single_res = 64'(!carry);
            OP_GT:    single_res = 64'(carry && (b_reg != a_reg));
            OP_LE:    single_res = 64'(!(carry && (b_reg != a_reg)));
            OP_GE:    single_res = 64'(carry);
            default:  single_res = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= OP_NOP;
            a_reg      <= 64'd0;
            b_reg      <= 64'd0;
            acc_reg    <= 64'd0;
            x_reg      <= 64'd0;
            y_reg      <= 64'd0;
            step_reg   <= 6'd0;
            result_reg <= 64'd0;
        end else begin
            if (req.start) begin
                done_reg <= 1'b0;
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                a_reg    <= opnd_a;
                b_reg    <= opnd_b;
                acc_reg  <= 64'd0;
                x_reg    <= (req.op == OP_MUL) ? opnd_a : opnd_b;
                y_reg    <= opnd_b;
                step_reg <= 6'd0;
            end else if (busy_reg) begin
                if (is_mul || is_div) begin
                    acc_reg  <= acc_step;
                    step_reg <= step_reg + 6'd1;
                    if (is_mul) begin
                        x_reg <= {1'b0, x_reg[63:1]};
                        y_reg <= {y_reg[62:0], 1'b0};
                    end else begin
                        x_reg <= {x_reg[62:0], carry};
                    end
                    if (step_reg == 6'd63) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        if (op_reg == OP_DIV) begin
                            result_reg <= {x_reg[62:0], carry};
                        end else begin
                            result_reg <= acc_step;
                        end
                    end else begin
                        done_reg <= 1'b0;
                    end
                end else begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    result_reg <= single_res;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

FILE: sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer, stacks and heap.
//
// One instruction request enters on the in channel (opcode and immediate)
// when in_valid and in_ready are both high; exactly one result request
// (status, next fetch address, top of stack, depth, halted flag) leaves on
// the out channel for each instruction. The unit works on one instruction
// at a time and raises in_ready only when the previous result has been taken.
// The sequencer reads popped operands and writes pushed entries one at a
// time; ALU operations run in the shared iterative unit, including multiply,
// divide and modulo, and heap loads and stores move one byte at a time on
// the single byte-wide heap port. After reset the heap is swept to zero one
// byte a cycle, with in_ready low. A stalled receiver holds the result in
// the output register and no new instruction is taken until it is accepted.
// Any fault, exit or fail halts the unit; later instructions only report
// the stored status until the next reset.
`default_nettype none
module stack_machine_execute_unit #(
    parameter int DATA_DEPTH    = smeu_pkg::DATA_DEPTH_DEF,
    parameter int CALL_DEPTH    = smeu_pkg::CALL_DEPTH_DEF,
    parameter int HEAP_BYTES    = smeu_pkg::HEAP_BYTES_DEF,
    parameter int PROGRAM_BYTES = smeu_pkg::PROGRAM_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire smeu_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output smeu_pkg::out_item_t     out_data
);
    import smeu_pkg::*;

    localparam int DA_W  = $clog2(DATA_DEPTH);
    localparam int CNT_W = $clog2(DATA_DEPTH + 1);
    localparam int RA_W  = $clog2(CALL_DEPTH);
    localparam int RC_W  = $clog2(CALL_DEPTH + 1);
    localparam int HA_W  = $clog2(HEAP_BYTES);
    localparam int PC_W  = $clog2(PROGRAM_BYTES);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_DECODE = 11'b00000000100,
        S_READ   = 11'b00000001000,
        S_EXEC   = 11'b00000010000,
        S_ALU    = 11'b00000100000,
        S_HEAP   = 11'b00001000000,
        S_WRITE  = 11'b00010000000,
        S_TOP    = 11'b00100000000,
        S_TOPCAP = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t          state_reg;
    logic [5:0]      op_reg;
    logic [63:0]     imm_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RC_W-1:0] rc_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] npc_reg;
    logic [2:0]      stop_reg;
    logic [2:0]      status_reg;
    logic [63:0]     top_reg;
    logic [63:0]     opnd_reg [3];
    logic [63:0]     res_reg [3];
    logic [1:0]      rd_k_reg;
    logic [1:0]      wr_k_reg;
    logic [3:0]      hk_reg;
    logic [3:0]      hw_reg;
    logic [HA_W-1:0] haddr_reg;
    logic [HA_W-1:0] clr_reg;

    logic [63:0]     ds_mem [DATA_DEPTH];
    logic [63:0]     ds_rd_reg;
    logic [PC_W-1:0] rs_mem [CALL_DEPTH];
    logic [PC_W-1:0] rs_rd_reg;
    logic [7:0]      hp_mem [HEAP_BYTES];
    logic [7:0]      hp_rd_reg;

    logic [1:0]      pops;
    logic [1:0]      pushes;
    logic [CNT_W:0]  newcnt;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] wr_pos;
    logic [CNT_W-1:0] rd_pos;
    logic [RC_W-1:0] rc_m1;
    logic            ds_we;
    logic            rs_we;
    logic            hp_we;
    logic [HA_W-1:0] hp_waddr;
    logic [7:0]      hp_wdata;
    logic [HA_W-1:0] hp_raddr;
    logic [3:0]      len;
    logic [PC_W:0]   pc_plus;
    logic [PC_W-1:0] seq;
    logic            is_alu;
    logic            is_heap;
    logic            is_br;
    logic            is_call;
    logic            taken;
    logic [3:0]      hw;
    logic [1:0]      hsel;
    logic            div_zero;
    alu_req_t        alu_req;
    logic            alu_done;
    logic [63:0]     alu_result;

    assign pops   = pops_of(op_reg);
    assign pushes = pushes_of(op_reg);
    assign newcnt = {1'b0, cnt_reg} - (CNT_W+1)'(pops) + (CNT_W+1)'(pushes);
    assign base   = cnt_reg - CNT_W'(pops);
    assign wr_pos = base + CNT_W'(wr_k_reg);
    assign rd_pos = (state_reg == S_READ) ? (cnt_reg - CNT_W'(1) - CNT_W'(rd_k_reg))
                                          : (cnt_reg - CNT_W'(1));
    assign rc_m1  = rc_reg - RC_W'(1);

    assign is_alu  = (op_reg >= OP_ADD && op_reg <= OP_BXNOR) || (op_reg >= OP_EQ);
    assign is_heap = (op_reg >= OP_LOAD1 && op_reg <= OP_STORE8);
    assign is_br   = (op_reg >= OP_JZ && op_reg <= OP_CALL);
    assign is_call = (op_reg == OP_CZ) || (op_reg == OP_CNZ) || (op_reg == OP_CALL);
    assign taken   = (op_reg > OP_CNZ) ? 1'b1
                   : (op_reg <= OP_CZ) ? (opnd_reg[0] == 64'd0) : (opnd_reg[0] != 64'd0);
    assign div_zero = ((op_reg == OP_DIV) || (op_reg == OP_MOD)) && (opnd_reg[0] == 64'd0);

    assign hsel = 2'((op_reg - OP_LOAD1) >> 1);
    assign hw   = 4'd1 << hsel;

    assign len     = (op_reg == OP_PUSH || is_br) ? 4'd9 : 4'd1;
    assign pc_plus = {1'b0, pc_reg} + (PC_W+1)'(len);
    // The sequential address wraps at the end of program space.
    assign seq     = (pc_plus >= (PC_W+1)'(PROGRAM_BYTES))
                   ? PC_W'(pc_plus - (PC_W+1)'(PROGRAM_BYTES)) : pc_plus[PC_W-1:0];

    assign alu_req.start = (state_reg == S_EXEC) && is_alu && !div_zero;
    assign alu_req.op    = op_reg;

    assign ds_we    = (state_reg == S_WRITE) && (wr_k_reg < pushes);
    assign rs_we    = (state_reg == S_EXEC) && is_br && is_call && taken
                      && (imm_reg < 64'(PROGRAM_BYTES)) && (rc_reg < RC_W'(CALL_DEPTH));
    assign hp_we    = (state_reg == S_CLEAR)
                      || ((state_reg == S_HEAP) && !op_reg[0] && (hk_reg != hw_reg));
    assign hp_waddr = (state_reg == S_CLEAR) ? clr_reg : (haddr_reg + HA_W'(hk_reg));
    assign hp_wdata = (state_reg == S_CLEAR) ? 8'd0
                                             : opnd_reg[1][{hk_reg[2:0], 3'b000} +: 8];
    assign hp_raddr = haddr_reg + HA_W'(hk_reg);

    smeu_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opnd_a (opnd_reg[0]),
        .opnd_b (opnd_reg[1]),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk) begin
        if (ds_we) begin
            ds_mem[wr_pos[DA_W-1:0]] <= res_reg[wr_k_reg];
        end
        ds_rd_reg <= ds_mem[rd_pos[DA_W-1:0]];
    end

    always_ff @(posedge clk) begin
        if (rs_we) begin
            rs_mem[rc_reg[RA_W-1:0]] <= seq;
        end
        rs_rd_reg <= rs_mem[rc_m1[RA_W-1:0]];
    end

    always_ff @(posedge clk) begin
        if (hp_we) begin
            hp_mem[hp_waddr] <= hp_wdata;
        end
        hp_rd_reg <= hp_mem[hp_raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_CLEAR;
            op_reg     <= OP_NOP;
            imm_reg    <= 64'd0;
            cnt_reg    <= '0;
            rc_reg     <= '0;
            pc_reg     <= '0;
            npc_reg    <= '0;
            stop_reg   <= ST_OK;
            status_reg <= ST_OK;
            top_reg    <= 64'd0;
            rd_k_reg   <= 2'd0;
            wr_k_reg   <= 2'd0;
            hk_reg     <= 4'd0;
            hw_reg     <= 4'd0;
            haddr_reg  <= '0;
            clr_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                opnd_reg[i] <= 64'd0;
                res_reg[i]  <= 64'd0;
            end
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + HA_W'(1);
                    if (clr_reg == HA_W'(HEAP_BYTES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        op_reg    <= in_data.mode;
                        imm_reg   <= in_data.immediate;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    rd_k_reg <= 2'd0;
                    wr_k_reg <= 2'd0;
                    priority if (stop_reg != ST_OK) begin
                        status_reg <= stop_reg;
                        state_reg  <= S_OUT;
                    end else if (op_reg > OP_GE) begin
                        status_reg <= ST_ILLEGAL;
                        stop_reg   <= ST_ILLEGAL;
                        state_reg  <= S_OUT;
                    end else if (op_reg == OP_EXIT) begin
                        status_reg <= ST_EXIT;
                        stop_reg   <= ST_EXIT;
                        state_reg  <= S_OUT;
                    end else if (op_reg == OP_FAIL) begin
                        status_reg <= ST_FAIL;
                        stop_reg   <= ST_FAIL;
                        state_reg  <= S_OUT;
                    end else if (cnt_reg < CNT_W'(pops)) begin
                        status_reg <= ST_UNDER;
                        stop_reg   <= ST_UNDER;
                        state_reg  <= S_OUT;
                    end else if (newcnt > (CNT_W+1)'(DATA_DEPTH)) begin
                        status_reg <= ST_OVER;
                        stop_reg   <= ST_OVER;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // Address k is issued while the word of address k-1 is captured.
                    if (rd_k_reg != 2'd0) begin
                        opnd_reg[rd_k_reg - 2'd1] <= ds_rd_reg;
                    end
                    if (rd_k_reg == pops) begin
                        state_reg <= S_EXEC;
                    end else begin
                        rd_k_reg <= rd_k_reg + 2'd1;
                    end
                end
                S_EXEC: begin
                    if (is_alu) begin
                        npc_reg <= seq;
                        if (div_zero) begin
                            status_reg <= ST_DIVZERO;
                            stop_reg   <= ST_DIVZERO;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_ALU;
                        end
                    end else if (is_heap) begin
                        npc_reg <= seq;
                        if (opnd_reg[0] > (64'(HEAP_BYTES) - 64'(hw))) begin
                            status_reg <= ST_BADADDR;
                            stop_reg   <= ST_BADADDR;
                            state_reg  <= S_OUT;
                        end else begin
                            haddr_reg  <= opnd_reg[0][HA_W-1:0];
                            hk_reg     <= 4'd0;
                            hw_reg     <= hw;
                            res_reg[0] <= 64'd0;
                            state_reg  <= S_HEAP;
                        end
                    end else if (is_br) begin
                        if (taken && imm_reg >= 64'(PROGRAM_BYTES)) begin
                            status_reg <= ST_BADADDR;
                            stop_reg   <= ST_BADADDR;
                            state_reg  <= S_OUT;
                        end else if (taken && is_call && rc_reg >= RC_W'(CALL_DEPTH)) begin
                            status_reg <= ST_OVER;
                            stop_reg   <= ST_OVER;
                            state_reg  <= S_OUT;
                        end else begin
                            if (taken && is_call) begin
                                rc_reg <= rc_reg + RC_W'(1);
                            end
                            npc_reg   <= taken ? imm_reg[PC_W-1:0] : seq;
                            state_reg <= S_WRITE;
                        end
                    end else if (op_reg == OP_RET) begin
                        if (rc_reg == '0) begin
                            status_reg <= ST_UNDER;
                            stop_reg   <= ST_UNDER;
                            state_reg  <= S_OUT;
                        end else begin
                            rc_reg    <= rc_m1;
                            npc_reg   <= rs_rd_reg;
                            state_reg <= S_WRITE;
                        end
                    end else begin
                        npc_reg   <= seq;
                        state_reg <= S_WRITE;
                        unique case (op_reg)
                            OP_PUSH: res_reg[0] <= imm_reg;
                            OP_DUP: begin
                                res_reg[0] <= opnd_reg[0];
                                res_reg[1] <= opnd_reg[0];
                            end
                            OP_ROT: begin
                                res_reg[0] <= opnd_reg[1];
                                res_reg[1] <= opnd_reg[0];
                                res_reg[2] <= opnd_reg[2];
                            end
                            OP_OVER: begin
                                res_reg[0] <= opnd_reg[1];
                                res_reg[1] <= opnd_reg[0];
                                res_reg[2] <= opnd_reg[1];
                            end
                            default: ;
                        endcase
                    end
                end
                S_ALU: begin
                    if (alu_done) begin
                        res_reg[0] <= alu_result;
                        state_reg  <= S_WRITE;
                    end
                end
                S_HEAP: begin
                    // Loads capture byte k-1 while byte k is being read.
                    if (op_reg[0] && hk_reg != 4'd0) begin
                        res_reg[0][{hk_reg[2:0] - 3'd1, 3'b000} +: 8] <= hp_rd_reg;
                    end
                    if (hk_reg == hw_reg) begin
                        state_reg <= S_WRITE;
                    end else begin
                        hk_reg <= hk_reg + 4'd1;
                    end
                end
                S_WRITE: begin
                    if (wr_k_reg == pushes) begin
                        cnt_reg   <= newcnt[CNT_W-1:0];
                        pc_reg    <= npc_reg;
                        state_reg <= S_TOP;
                    end else begin
                        wr_k_reg <= wr_k_reg + 2'd1;
                    end
                end
                S_TOP: begin
                    state_reg <= S_TOPCAP;
                end
                S_TOPCAP: begin
                    top_reg    <= (cnt_reg == '0) ? 64'd0 : ds_rd_reg;
                    status_reg <= ST_OK;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready              = (state_reg == S_IDLE);
    assign out_valid             = (state_reg == S_OUT);
    assign out_data.status       = status_reg;
    assign out_data.next_pc      = 15'(pc_reg);
    assign out_data.top_value    = top_reg;
    assign out_data.stack_depth  = 10'(cnt_reg);
    assign out_data.halted       = (stop_reg != ST_OK);

`include "stack_machine_execute_unit_assert.svh"

    `SMEU_ASSERT(a_one_side, !(in_ready && out_valid), "input taken while a result is pending")
    `SMEU_ASSERT(a_depth_bound, int'(cnt_reg) <= DATA_DEPTH, "data stack count out of range")
    `SMEU_ASSERT(a_call_bound, int'(rc_reg) <= CALL_DEPTH, "return stack count out of range")
    `SMEU_ASSERT_NEXT(a_halt_sticky, stop_reg != ST_OK, stop_reg == $past(stop_reg), "halt status changed")
    `SMEU_ASSERT(a_halt_status, (out_valid && out_data.halted) |-> (out_data.status != ST_OK), "halted result reports ok")

endmodule
`default_nettype wire

FILE: tb/stack_machine_execute_unit_tb.sv
// Self-checking testbench of the stack machine execute unit, with its own predictor.
`default_nettype none
module stack_machine_execute_unit_tb;
    import smeu_pkg::*;

    localparam int DEPTH_LIMIT  = 512;
    localparam int CALL_LIMIT   = 256;
    localparam int HEAP_SPAN    = 32768;
    localparam int PROG_SIZE    = 32768;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [5:0] OP_STORE1 = 6'd26;
    localparam logic [5:0] OP_LOAD2  = 6'd27;
    localparam logic [5:0] OP_STORE2 = 6'd28;
    localparam logic [5:0] OP_LOAD4  = 6'd29;
    localparam logic [5:0] OP_STORE4 = 6'd30;
    localparam logic [5:0] OP_LOAD8  = 6'd31;
    localparam logic [5:0] OP_FIRST_ILLEGAL = 6'd46;
    localparam logic [5:0] OP_LAST_ILLEGAL  = 6'd63;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    stack_machine_execute_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Shadow machine state.
    bit [63:0] shadow_stack [DEPTH_LIMIT];
    int        shadow_depth;
    bit [14:0] shadow_returns [CALL_LIMIT];
    int        shadow_calls;
    bit [7:0]  shadow_heap [HEAP_SPAN];
    int        shadow_pc;
    logic [2:0] shadow_stop;

    out_item_t pending_results [$];
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  failed = 1'b0;
    longint cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("stack_machine_execute_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status || out_data.next_pc !== want.next_pc
                    || out_data.top_value !== want.top_value
                    || out_data.stack_depth !== want.stack_depth
                    || out_data.halted !== want.halted)
                begin
                    $display("%0t: expected %p actual %p", $time, want, out_data);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic int operands_needed(logic [5:0] op);
        case (op)
            OP_ROT: return 3;
            OP_DROP, OP_DUP, OP_LNOT, OP_BNOT, OP_JZ, OP_CZ, OP_JNZ, OP_CNZ: return 1;
            OP_LOAD1, OP_LOAD2, OP_LOAD4, OP_LOAD8: return 1;
            OP_STORE1, OP_STORE2, OP_STORE4, OP_STORE8: return 2;
            default: return ((op >= OP_ADD && op <= OP_BXNOR) || op == OP_OVER
                             || (op >= OP_EQ && op <= OP_GE)) ? 2 : 0;
        endcase
    endfunction

    function automatic int entries_made(logic [5:0] op);
        case (op)
            OP_ROT, OP_OVER: return 3;
            OP_DUP: return 2;
            OP_LOAD1, OP_LOAD2, OP_LOAD4, OP_LOAD8, OP_PUSH: return 1;
            default: return ((op >= OP_ADD && op <= OP_BXNOR)
                             || (op >= OP_EQ && op <= OP_GE)) ? 1 : 0;
        endcase
    endfunction

    function automatic int access_width(logic [5:0] op);
        return 1 << ((op - OP_LOAD1) >> 1);
    endfunction

    // Status the instruction would end with, without touching the shadow state.
    function automatic logic [2:0] fault_of(logic [5:0] op, logic [63:0] imm);
        logic [63:0] top;
        bit taken;
        if (op >= OP_FIRST_ILLEGAL) return ST_ILLEGAL;
        if (op == OP_EXIT) return ST_EXIT;
        if (op == OP_FAIL) return ST_FAIL;
        if (shadow_depth < operands_needed(op)) return ST_UNDER;
        if (shadow_depth - operands_needed(op) + entries_made(op) > DEPTH_LIMIT) return ST_OVER;
        top = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : 64'd0;
        if ((op == OP_DIV || op == OP_MOD) && top == 0) return ST_DIVZERO;
        if (op >= OP_LOAD1 && op <= OP_STORE8 && top > 64'(HEAP_SPAN - access_width(op)))
            return ST_BADADDR;
        if (op >= OP_JZ && op <= OP_CALL)
        begin
            taken = (op >= OP_JMP) ? 1'b1 : (op <= OP_CZ) ? (top == 0) : (top != 0);
            if (taken && imm >= 64'(PROG_SIZE)) return ST_BADADDR;
            if (taken && (op == OP_CZ || op == OP_CNZ || op == OP_CALL)
                && shadow_calls >= CALL_LIMIT) return ST_OVER;
        end
        if (op == OP_RET && shadow_calls == 0) return ST_UNDER;
        return ST_OK;
    endfunction

    function automatic out_item_t snapshot(logic [2:0] st);
        out_item_t o;
        o.status = st;
        o.next_pc = shadow_pc[14:0];
        o.top_value = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : 64'd0;
        o.stack_depth = shadow_depth[9:0];
        o.halted = (shadow_stop != ST_OK);
        return o;
    endfunction

    function automatic logic [63:0] pop_value();
        shadow_depth--;
        return shadow_stack[shadow_depth];
    endfunction

    function automatic void push_value(logic [63:0] v);
        shadow_stack[shadow_depth] = v;
        shadow_depth++;
    endfunction

    function automatic out_item_t execute_step(in_item_t it);
        logic [5:0]  op;
        logic [63:0] imm, a, b, c, r;
        logic [2:0]  st;
        int seq_pc, next_pc, w, addr;
        bit taken;
        op = it.mode;
        imm = it.immediate;
        r = 64'd0;
        if (shadow_stop != ST_OK) return snapshot(shadow_stop);
        st = fault_of(op, imm);
        if (st != ST_OK)
        begin
            shadow_stop = st;
            return snapshot(st);
        end
        seq_pc = (shadow_pc + ((op == OP_PUSH || (op >= OP_JZ && op <= OP_CALL)) ? 9 : 1))
                 % PROG_SIZE;
        next_pc = seq_pc;
        if (op >= OP_ADD && op <= OP_BXNOR)
        begin
            a = pop_value();
            b = (op == OP_LNOT || op == OP_BNOT) ? 64'd0 : pop_value();
            case (op)
                OP_ADD:   r = b + a;
                OP_SUB:   r = b - a;
                OP_MUL:   r = b * a;
                OP_DIV:   r = b / a;
                OP_MOD:   r = b % a;
                OP_LAND:  r = 64'(b != 0 && a != 0);
                OP_BAND:  r = b & a;
                OP_LOR:   r = 64'(b != 0 || a != 0);
                OP_BOR:   r = b | a;
                OP_LNOT:  r = 64'(a == 0);
                OP_BNOT:  r = ~a;
                OP_LXOR:  r = 64'((a != 0) != (b != 0));
                OP_BXOR:  r = b ^ a;
                OP_LNOR:  r = 64'(!(a != 0 || b != 0));
                OP_BNOR:  r = ~(b | a);
                OP_LXNOR: r = 64'((a != 0) == (b != 0));
                default:  r = ~(b ^ a);
            endcase
            push_value(r);
        end
        else if (op >= OP_LOAD1 && op <= OP_STORE8)
        begin
            w = access_width(op);
            addr = int'(pop_value());
            if (op[0])
            begin
                for (int i = 0; i < w; i++) r |= 64'(shadow_heap[addr + i]) << (8 * i);
                push_value(r);
            end
            else
            begin
                c = pop_value();
                for (int i = 0; i < w; i++) shadow_heap[addr + i] = c[8 * i +: 8];
            end
        end
        else if (op >= OP_JZ && op <= OP_CALL)
        begin
            taken = 1'b1;
            if (op <= OP_CNZ)
            begin
                c = pop_value();
                taken = (op <= OP_CZ) ? (c == 0) : (c != 0);
            end
            if (taken)
            begin
                if (op == OP_CZ || op == OP_CNZ || op == OP_CALL)
                begin
                    shadow_returns[shadow_calls] = seq_pc[14:0];
                    shadow_calls++;
                end
                next_pc = int'(imm);
            end
        end
        else if (op == OP_RET)
        begin
            shadow_calls--;
            next_pc = int'(shadow_returns[shadow_calls]);
        end
        else if (op >= OP_EQ)
        begin
            a = pop_value();
            b = pop_value();
            case (op)
                OP_EQ:   r = 64'(b == a);
                OP_NE:   r = 64'(b != a);
                OP_LT:   r = 64'(b < a);
                OP_GT:   r = 64'(b > a);
                OP_LE:   r = 64'(b <= a);
                default: r = 64'(b >= a);
            endcase
            push_value(r);
        end
        else
        begin
            case (op)
                OP_PUSH: push_value(imm);
                OP_DROP: shadow_depth--;
                OP_DUP:  push_value(shadow_stack[shadow_depth - 1]);
                OP_ROT:
                begin
                    c = pop_value();
                    b = pop_value();
                    a = pop_value();
                    push_value(b);
                    push_value(c);
                    push_value(a);
                end
                OP_OVER: push_value(shadow_stack[shadow_depth - 2]);
                default: ;
            endcase
        end
        shadow_pc = next_pc;
        return snapshot(ST_OK);
    endfunction

    // Drives one request, waits for its acceptance and records the expected result.
    task automatic send_instruction(logic [5:0] op, logic [63:0] imm);
        in_item_t it;
        it.mode = op;
        it.immediate = imm;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(execute_step(it));
    endtask

    function automatic logic [63:0] random_value();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 15));
            3: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_target();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'(PROG_SIZE - 1);
            default: return 64'($urandom_range(0, PROG_SIZE - 1));
        endcase
    endfunction

    // Well-formed heap access: address (and value) pushed, then load or store.
    task automatic heap_sequence();
        logic [5:0] op;
        int w, addr;
        op = OP_LOAD1 + 6'($urandom_range(0, 7));
        w = access_width(op);
        addr = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, HEAP_SPAN - w))
                                          : int'($urandom_range(0, 48));
        if ($urandom_range(0, 9) == 0) addr = HEAP_SPAN - w;
        if (shadow_depth + 2 > DEPTH_LIMIT) return;
        if (!op[0]) send_instruction(OP_PUSH, random_value());
        send_instruction(OP_PUSH, 64'(addr));
        send_instruction(op, random_value());
    endtask

    // One legal instruction picked at random; it never halts the machine.
    task automatic random_instruction();
        logic [5:0]  op;
        logic [63:0] imm;
        int tries;
        tries = 0;
        do
        begin
            if ($urandom_range(0, 3) == 0 || shadow_depth < 2) op = OP_PUSH;
            else if (shadow_depth > 48 && $urandom_range(0, 1) == 0) op = OP_DROP;
            else op = 6'($urandom_range(0, 45));
            imm = (op >= OP_JZ && op <= OP_CALL) ? random_target() : random_value();
            tries++;
        end
        while (fault_of(op, imm) != ST_OK && tries < 30);
        if (fault_of(op, imm) != ST_OK)
        begin
            op = OP_NOP;
        end
        send_instruction(op, imm);
    endtask

    task automatic test_directed();
        send_instruction(OP_NOP, '1);
        send_instruction(OP_PUSH, '1);
        send_instruction(OP_PUSH, 64'd1);
        send_instruction(OP_ADD, 64'd0);
        send_instruction(OP_PUSH, 64'h8000_0000_0000_0000);
        send_instruction(OP_OVER, 64'd0);
        send_instruction(OP_MUL, 64'd0);
        send_instruction(OP_PUSH, 64'd3);
        send_instruction(OP_ROT, 64'd0);
        send_instruction(OP_DUP, 64'd0);
        send_instruction(OP_PUSH, 64'd7);
        send_instruction(OP_MOD, 64'd0);
        send_instruction(OP_PUSH, '1);
        send_instruction(OP_PUSH, 64'(HEAP_SPAN - 8));
        send_instruction(OP_STORE8, 64'd0);
        send_instruction(OP_PUSH, 64'(HEAP_SPAN - 8));
        send_instruction(OP_LOAD8, 64'd0);
        send_instruction(OP_CALL, 64'(PROG_SIZE - 4));
        // The push straddles the end of program space and wraps to a low address.
        send_instruction(OP_PUSH, 64'd0);
        send_instruction(OP_CZ, 64'd100);
        send_instruction(OP_RET, 64'd0);
        send_instruction(OP_RET, 64'd0);
        send_instruction(OP_LT, 64'd0);
        send_instruction(OP_JNZ, 64'd0);
        send_instruction(OP_BXNOR, 64'd0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
        int sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 6) == 0) heap_sequence();
            else random_instruction();
            sent++;
        end
    endtask

    // Drives the machine into one fault or exit, then checks that it stays halted.
    task automatic test_halt();
        case ($urandom_range(0, 7))
            0: send_instruction(OP_EXIT, '1);
            1: send_instruction(OP_FAIL, 64'd0);
            2: send_instruction(6'($urandom_range(OP_FIRST_ILLEGAL, OP_LAST_ILLEGAL)), '1);
            3:
            begin
                while (shadow_depth > 0) send_instruction(OP_DROP, 64'd0);
                send_instruction(OP_DROP, 64'd0);
            end
            4:
            begin
                while (shadow_depth < DEPTH_LIMIT) send_instruction(OP_PUSH, random_value());
                send_instruction(OP_DUP, 64'd0);
            end
            5:
            begin
                send_instruction(OP_PUSH, 64'd9);
                send_instruction(OP_PUSH, 64'd0);
                send_instruction(OP_DIV, 64'd0);
            end
            6:
            begin
                send_instruction(OP_PUSH, 64'(HEAP_SPAN - 1));
                send_instruction(OP_LOAD2, 64'd0);
            end
            default: send_instruction(OP_JMP, 64'(PROG_SIZE));
        endcase
        repeat (8) send_instruction(6'($urandom_range(0, 63)), random_value());
    endtask

    initial
    begin
        shadow_depth = 0;
        shadow_calls = 0;
        shadow_pc = 0;
        shadow_stop = ST_OK;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(0, 0, 250);
        test_random_traffic(68, 0, 250);
        test_random_traffic(0, 68, 250);
        test_random_traffic(15, 15, 250);
        test_halt();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("stack_machine_execute_unit regression: pass");
        else
            $display("stack_machine_execute_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
